FILE: design/mrs_pkg.sv
package mrs_pkg;

  localparam int NUM_BINS = 64;
  localparam int REGION_W = 6;
  localparam int VALUE_W  = 32;
  localparam int SUM_W    = 48;
  localparam int CNT_W    = 7;
  localparam int EXT_W    = SUM_W + 1 - VALUE_W;

  localparam logic [CNT_W-1:0] NB_MAX = CNT_W'(NUM_BINS);
  localparam logic [CNT_W-1:0] NB_MIN = CNT_W'(1);
  localparam logic [CNT_W-1:0] NB_RST = CNT_W'(64);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_READ,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic run;
    logic rd;
    logic show;
    logic adv;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic fend_acc;
    logic out_fire;
    logic last;
  } stat_t;

endpackage

FILE: design/mrs_ram.sv
module mrs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/mrs_ctrl.sv
module mrs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  mrs_pkg::stat_t stat,
  output mrs_pkg::cmd_t  cmd
);
  import mrs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (stat.fend_acc) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (stat.out_fire) begin
          state_nxt = stat.last ? ST_RUN : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_RUN: begin
        cmd.run = 1'b1;
      end
      ST_DRAIN: begin
        cmd.run = 1'b0;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
      end
      ST_SHOW: begin
        cmd.show  = 1'b1;
        cmd.adv   = stat.out_fire && !stat.last;
        cmd.clear = stat.out_fire && stat.last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: design/mrs_dp.sv
module mrs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mrs_pkg::cmd_t                       cmd,
  output mrs_pkg::stat_t                      stat,
  input  logic                                cfg_we,
  input  logic [mrs_pkg::CNT_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mrs_pkg::REGION_W-1:0]        in_region,
  input  logic signed [mrs_pkg::VALUE_W-1:0]  in_cell_value,
  input  logic                                in_frame_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mrs_pkg::REGION_W-1:0]        out_bin_index,
  output logic signed [mrs_pkg::SUM_W-1:0]    out_bin_sum,
  output logic                                out_last_bin
);
  import mrs_pkg::*;

  logic [CNT_W-1:0]           num_bins_r;
  logic [CNT_W-1:0]           nb;
  logic                       in_fire;
  logic                       in_range;
  logic                       s1_vld_r;
  logic                       s1_fwd_r;
  logic [REGION_W-1:0]        s1_region_r;
  logic signed [VALUE_W-1:0]  s1_value_r;
  logic                       vld_rd_r;
  logic signed [SUM_W-1:0]    last_sum_r;
  logic [NUM_BINS-1:0]        valid_r;
  logic [REGION_W-1:0]        bin_cnt_r;
  logic                       ram_re;
  logic [REGION_W-1:0]        ram_raddr;
  logic [SUM_W-1:0]           ram_rdata;
  logic signed [SUM_W-1:0]    base;
  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W-1:0]    sum_sat;

  // Effective bin count, clamped to 1 .. NUM_BINS.
  always_comb begin
    if (num_bins_r < NB_MIN) begin
      nb = NB_MIN;
    end else if (num_bins_r > NB_MAX) begin
      nb = NB_MAX;
    end else begin
      nb = num_bins_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r <= NB_RST;
    end else if (cfg_we) begin
      num_bins_r <= cfg_wdata;
    end
  end

  assign in_ready  = cmd.run;
  assign in_fire   = in_valid && in_ready;
  assign in_range  = {1'b0, in_region} < nb;
  assign ram_re    = in_fire || cmd.rd;
  assign ram_raddr = cmd.rd ? bin_cnt_r : in_region;

  // Control state of the accumulate stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_fwd_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire && in_range;
      s1_fwd_r <= in_fire && in_range && s1_vld_r && (s1_region_r == in_region);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_region_r <= in_region;
      s1_value_r  <= in_cell_value;
    end
    if (ram_re) begin
      vld_rd_r <= valid_r[ram_raddr];
    end
    if (s1_vld_r) begin
      last_sum_r <= sum_sat;
    end
  end

  // A back-to-back hit on the same region takes the sum still being written.
  assign base     = s1_fwd_r ? last_sum_r : (vld_rd_r ? $signed(ram_rdata) : '0);
  assign sum_wide = {base[SUM_W-1], base} + {{EXT_W{s1_value_r[VALUE_W-1]}}, s1_value_r};

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
    end else if (s1_vld_r) begin
      valid_r[s1_region_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
    end else if (cmd.clear) begin
      bin_cnt_r <= '0;
    end else if (cmd.adv) begin
      bin_cnt_r <= bin_cnt_r + REGION_W'(1);
    end
  end

  mrs_ram #(
    .WIDTH(SUM_W),
    .DEPTH(NUM_BINS)
  ) u_sums (
    .clk  (clk),
    .we   (s1_vld_r),
    .waddr(s1_region_r),
    .wdata(sum_sat),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid     = cmd.show;
  assign out_bin_index = bin_cnt_r;
  assign out_bin_sum   = vld_rd_r ? $signed(ram_rdata) : '0;
  assign out_last_bin  = ({1'b0, bin_cnt_r} == (nb - NB_MIN));

  assign stat.fend_acc = in_fire && in_frame_end;
  assign stat.out_fire = out_valid && out_ready;
  assign stat.last     = out_last_bin;

  a_fwd_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> s1_vld_r)
    else $error("forward flag set without a pending write");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.clear) |-> (valid_r == '0))
    else $error("valid bits not cleared after dump");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_bin_index} < nb))
    else $error("dump index beyond bin count");

  a_no_write_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !s1_vld_r)
    else $error("accumulate write during dump");

endmodule

FILE: design/masked_region_sum_top.sv
// Binned accumulator (weighted histogram). Each input item carries a region
// number and a signed Q16.16 value; the value is added with saturation to that
// region's signed Q32.16 running sum, held in a 64 x 48 single-port-read RAM.
// Items whose region is at or above the effective bin count (cfg num_bins,
// clamped to 1..64) are not accumulated. Ordinary items are taken one per
// cycle; a read-modify-write hazard on the same region in consecutive cycles
// is covered by forwarding the sum being written. An item with frame_end set
// is accumulated if in range, then after a drain state the block emits one
// result item per bin, index 0 upward, with out_last_bin on the final one.
// Each result passes through a RAM read state and then a show state that
// waits for out_ready, so the next bin is read only after the last is taken;
// no input is taken while a dump is running. The sums
// are cleared by per-entry valid bits that reset and the end of each dump
// clear at once, so there is no clearing pass after reset. num_bins is
// written through cfg_we and cfg_wdata and must only change while the block
// is idle.
module masked_region_sum_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mrs_pkg::CNT_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mrs_pkg::REGION_W-1:0]        in_region,
  input  logic signed [mrs_pkg::VALUE_W-1:0]  in_cell_value,
  input  logic                                in_frame_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mrs_pkg::REGION_W-1:0]        out_bin_index,
  output logic signed [mrs_pkg::SUM_W-1:0]    out_bin_sum,
  output logic                                out_last_bin
);
  import mrs_pkg::*;

  // Commands flow from the controller, status flows back from the datapath.
  cmd_t  cmd;
  stat_t stat;

  mrs_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .cmd  (cmd)
  );

  mrs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_region    (in_region),
    .in_cell_value(in_cell_value),
    .in_frame_end (in_frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_bin_index(out_bin_index),
    .out_bin_sum  (out_bin_sum),
    .out_last_bin (out_last_bin)
  );

endmodule

FILE: sim/region_sum_checker.sv
module region_sum_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mrs_pkg::CNT_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [mrs_pkg::REGION_W-1:0]        in_region,
  input  logic signed [mrs_pkg::VALUE_W-1:0]  in_cell_value,
  input  logic                                in_frame_end,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [mrs_pkg::REGION_W-1:0]        out_bin_index,
  input  logic signed [mrs_pkg::SUM_W-1:0]    out_bin_sum,
  input  logic                                out_last_bin,
  output int                                  mismatches,
  output int                                  results_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import mrs_pkg::*;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic [SUM_W-1:0]    sum;
    logic                last;
  } bin_result_t;

  logic signed [SUM_W-1:0] region_sums [NUM_BINS];
  logic [CNT_W-1:0]        bins_cfg;
  bin_result_t             expected_bins [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [CNT_W-1:0] active_bins(input logic [CNT_W-1:0] n);
    if (n < NB_MIN) begin
      return NB_MIN;
    end
    if (n > NB_MAX) begin
      return NB_MAX;
    end
    return n;
  endfunction

  function automatic logic signed [SUM_W-1:0] add_saturated(
    input logic signed [SUM_W-1:0]   acc,
    input logic signed [VALUE_W-1:0] value
  );
    logic [SUM_W:0] wide;
    wide = {acc[SUM_W-1], acc} + {{EXT_W{value[VALUE_W-1]}}, value};
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      return wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return wide[SUM_W-1:0];
  endfunction

  task automatic accumulate_cell(
    input logic [REGION_W-1:0]       region,
    input logic signed [VALUE_W-1:0] value,
    input logic                      fend
  );
    logic [CNT_W-1:0] nb;
    bin_result_t      res;
    nb = active_bins(bins_cfg);
    if (CNT_W'(region) < nb) begin
      region_sums[region] = add_saturated(region_sums[region], value);
    end
    if (fend) begin
      for (int i = 0; i < int'(nb); i++) begin
        res.region = REGION_W'(i);
        res.sum    = region_sums[i];
        res.last   = (i == int'(nb) - 1);
        expected_bins = {expected_bins, res};
      end
      // The whole store is cleared, not only the bins that were emitted.
      foreach (region_sums[i]) begin
        region_sums[i] = '0;
      end
    end
  endtask

  task automatic compare_bin(input bin_result_t want);
    if (out_bin_index !== want.region) begin
      report_mismatch($sformatf("bin_index %0d, expected %0d", out_bin_index, want.region));
    end
    if (out_bin_sum !== want.sum) begin
      report_mismatch($sformatf("bin %0d sum %0d, expected %0d", want.region,
                                out_bin_sum, $signed(want.sum)));
    end
    if (out_last_bin !== want.last) begin
      report_mismatch($sformatf("bin %0d last_bin %0b, expected %0b", want.region,
                                out_last_bin, want.last));
    end
  endtask

  always @(posedge clk) begin : watch
    if (!rst_n) begin
      foreach (region_sums[i]) begin
        region_sums[i] = '0;
      end
      bins_cfg = NB_RST;
      expected_bins.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bins.size() == 0) begin
          report_mismatch($sformatf("unexpected result for bin %0d", out_bin_index));
        end else begin
          compare_bin(expected_bins.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        accumulate_cell(in_region, in_cell_value, in_frame_end);
      end
      if (cfg_we) begin
        bins_cfg = cfg_wdata;
      end
    end
    results_pending = expected_bins.size();
  end

endmodule

FILE: sim/tb_masked_region_sum_top.sv
module tb_masked_region_sum_top;

  timeunit 1ns;
  timeprecision 1ps;

  import mrs_pkg::*;

  // Cycles allowed for the block to finish an item that produces no result
  // before the bin count is changed, and the quiet time at the very end,
  // long enough for a full dump to show up if one were wrongly started.
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 2 * NUM_BINS + 24;
  // Length of the long receiver hold-off that backs the block up.
  localparam int LONG_HOLD     = 400;
  // Full-scale cells sent to each of the two loaded regions.
  localparam int BIG_ITEMS     = 4;

  logic                      clk           = 1'b0;
  logic                      rst_n         = 1'b0;
  logic                      cfg_we        = 1'b0;
  logic [CNT_W-1:0]          cfg_wdata     = '0;
  logic                      in_valid      = 1'b0;
  logic                      in_ready;
  logic [REGION_W-1:0]       in_region     = '0;
  logic signed [VALUE_W-1:0] in_cell_value = '0;
  logic                      in_frame_end  = 1'b0;
  logic                      out_valid;
  logic                      out_ready     = 1'b0;
  logic [REGION_W-1:0]       out_bin_index;
  logic signed [SUM_W-1:0]   out_bin_sum;
  logic                      out_last_bin;

  int mismatches;
  int results_pending;

  // Idle percentages for the two sides, changed from phase to phase.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // The stimulus asks for a long hold-off by bumping hold_asked; the
  // receiver process notices and counts the hold-off down on its own.
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;

  // Effective bin count as the stimulus sees it, used only to aim regions.
  int active_nb = NUM_BINS;

  // Bin count settings for the random phases; two are drawn at run time.
  int phase_bins [8] = '{1, 65, 5, 13, 33, 64, 0, 0};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  masked_region_sum_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_region     (in_region),
    .in_cell_value (in_cell_value),
    .in_frame_end  (in_frame_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bin_index (out_bin_index),
    .out_bin_sum   (out_bin_sum),
    .out_last_bin  (out_last_bin)
  );

  region_sum_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_region       (in_region),
    .in_cell_value   (in_cell_value),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bin_index   (out_bin_index),
    .out_bin_sum     (out_bin_sum),
    .out_last_bin    (out_last_bin),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  // Receiver. It stalls at random at the current rate, except while a long
  // hold-off is running, during which it refuses every result.
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one cell item and returns at the falling edge after it was taken.
  // Valid stays high into the next item unless an idle gap is drawn, so it
  // is never lowered and raised within the same step.
  task automatic send_cell(
    input logic [REGION_W-1:0]       region,
    input logic signed [VALUE_W-1:0] value,
    input logic                      fend
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_region     <= region;
    in_cell_value <= value;
    in_frame_end  <= fend;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Brings the block to rest: the input goes quiet, every expected sum must
  // have come out, and a few more cycles cover cells that produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (results_pending != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the bin count once the block is idle.
  task automatic set_bins(input logic [CNT_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (value < NB_MIN) begin
      active_nb = 1;
    end else if (value > NB_MAX) begin
      active_nb = NUM_BINS;
    end else begin
      active_nb = int'(value);
    end
  endtask

  // Most cells land in a live region; the rest may fall above the bin count
  // and must be dropped by the block.
  function automatic logic [REGION_W-1:0] pick_region();
    if ($urandom_range(99) < 85) begin
      return REGION_W'($urandom_range(active_nb - 1));
    end
    return REGION_W'($urandom_range(NUM_BINS - 1));
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(9)) inside
      0:       v = {1'b0, {(VALUE_W-1){1'b1}}};
      1:       v = {1'b1, {(VALUE_W-1){1'b0}}};
      [2:4]:   v = $urandom;
      default: begin
        v = $urandom_range(4000);
        v = v - 2000;
      end
    endcase
    return v;
  endfunction

  // Sends whole frames of random length with random content; the final
  // cell of each frame carries frame_end so every phase ends flushed.
  task automatic run_frames(input int n_items);
    int sent;
    int frame_len;
    sent = 0;
    while (sent < n_items) begin
      frame_len = $urandom_range(12, 1);
      if (frame_len > n_items - sent) begin
        frame_len = n_items - sent;
      end
      for (int k = 0; k < frame_len; k++) begin
        send_cell(pick_region(), pick_value(), k == frame_len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed cells at the reset bin count of 64, with no idling at all.
    // Region and value extremes, a frame ending in the top region, and the
    // same region hit on consecutive cycles to stress the accumulate path.
    send_cell(6'd0, {1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
    send_cell(6'd63, {1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
    send_cell(6'd0, -32'sd1, 1'b0);
    send_cell(6'd7, 32'sd1000, 1'b0);
    send_cell(6'd7, 32'sd2000, 1'b0);
    send_cell(6'd7, -32'sd500, 1'b0);
    send_cell(6'd63, 32'sd0, 1'b1);

    // A bin count of zero behaves as one: region 1 is dropped, and a frame
    // end on an out-of-range region still dumps the single bin.
    set_bins(CNT_W'(0));
    send_cell(6'd0, 32'sd123, 1'b0);
    send_cell(6'd1, 32'sd55, 1'b0);
    send_cell(6'd40, 32'sd9, 1'b1);

    // A count above the maximum behaves as the maximum.
    set_bins(CNT_W'(127));
    send_cell(6'd63, {1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
    send_cell(6'd63, {1'b0, {(VALUE_W-1){1'b1}}}, 1'b1);

    // Full-scale values of both signs piled onto regions 1 and 2 back to
    // back, then each pulled back a little.
    set_bins(CNT_W'(4));
    for (int k = 0; k < BIG_ITEMS; k++) begin
      send_cell(6'd1, {1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
      send_cell(6'd2, {1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
    end
    send_cell(6'd1, -32'sd7, 1'b0);
    send_cell(6'd2, 32'sd7, 1'b0);
    send_cell(6'd3, {1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
    send_cell(6'd0, 32'sd0, 1'b1);

    // Random phases. The idling mode rotates through no idling, an idle
    // sender, a stalling receiver, and both; one phase also backs the
    // block up behind a long hold-off while cells keep coming.
    phase_bins[6] = $urandom_range(NUM_BINS, 1);
    phase_bins[7] = $urandom_range(NUM_BINS, 1);
    for (int p = 0; p < 8; p++) begin
      set_bins(CNT_W'(phase_bins[p]));
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 53;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 53;
        end
        default: begin
          send_idle_pct = 10;
          stall_pct     = 10;
        end
      endcase
      if (p == 4) begin
        hold_asked = hold_asked + 1;
      end
      run_frames(24);
    end

    // Let everything drain with a ready receiver, then watch for strays.
    in_valid      <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    while (results_pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: masked_region_sum_top.f
design/mrs_pkg.sv
design/mrs_ram.sv
design/mrs_ctrl.sv
design/mrs_dp.sv
design/masked_region_sum_top.sv
sim/region_sum_checker.sv
sim/tb_masked_region_sum_top.sv
